// ===== rtl/core/ept_pkg.sv =====
// Shared types and constants for the encoder position trigger window unit.
package ept_pkg;

    // History patterns: all lows then 8 highs (rise), then 8 lows (fall)
    localparam logic [15:0] RISE_PATTERN = 16'd255;
    localparam logic [15:0] FALL_PATTERN = 16'd65280;

    localparam int CFG_ADDR_BITS = 4;
    localparam int CNT_BITS      = 16;
    // Window bound width: start + slip + width always fits in 19 bits signed
    localparam int BOUND_BITS    = 19;

    // Register indexes (paddr[3:2])
    typedef enum logic [1:0] {
        REG_RUN_LENGTH     = 2'd0,
        REG_START_POSITION = 2'd1,
        REG_SLIP_OFFSET    = 2'd2,
        REG_PULSE_WIDTH    = 2'd3
    } reg_idx_t;

    localparam logic [15:0] RUN_LENGTH_RST     = 16'd500;
    localparam logic [15:0] START_POSITION_RST = 16'd250;
    localparam logic [15:0] SLIP_OFFSET_RST    = 16'd0;
    localparam logic [15:0] PULSE_WIDTH_RST    = 16'd5;

    typedef struct packed {
        logic [15:0]        run_length;
        logic [15:0]        start_position;
        logic signed [15:0] slip_offset;
        logic [15:0]        pulse_width;
    } cfg_t;

    typedef struct packed {
        logic rise;
        logic fall;
    } edge_t;

endpackage

// ===== rtl/core/ept_cfg.sv =====
// APB register file holding the trigger window configuration.
module ept_cfg
    import ept_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    output cfg_t                     cfg
);

    cfg_t     cfg_reg;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign cfg    = cfg_reg;

    // Register writes; run length of zero is held as one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.run_length     <= RUN_LENGTH_RST;
            cfg_reg.start_position <= START_POSITION_RST;
            cfg_reg.slip_offset    <= SLIP_OFFSET_RST;
            cfg_reg.pulse_width    <= PULSE_WIDTH_RST;
        end else if (wr_en) begin
            case (idx)
                REG_RUN_LENGTH: begin
                    cfg_reg.run_length <= (pwdata[15:0] == 16'd0) ? 16'd1 : pwdata[15:0];
                end
                REG_START_POSITION: cfg_reg.start_position <= pwdata[15:0];
                REG_SLIP_OFFSET:    cfg_reg.slip_offset    <= pwdata[15:0];
                REG_PULSE_WIDTH:    cfg_reg.pulse_width    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Readback
    always_comb begin
        case (idx)
            REG_RUN_LENGTH:     prdata = {16'd0, cfg_reg.run_length};
            REG_START_POSITION: prdata = {16'd0, cfg_reg.start_position};
            REG_SLIP_OFFSET:    prdata = {16'd0, cfg_reg.slip_offset};
            REG_PULSE_WIDTH:    prdata = {16'd0, cfg_reg.pulse_width};
            default:            prdata = 32'd0;
        endcase
    end

endmodule

// ===== rtl/core/ept_edge_detect.sv =====
// Sample history shift register and qualified rise/fall pattern match.
module ept_edge_detect
    import ept_pkg::*;
#(
    parameter int HISTORY_BITS = 32
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  sample_en,
    input  logic  level,
    output edge_t edges
);

    logic [HISTORY_BITS-1:0] hist_reg;
    logic [HISTORY_BITS-1:0] hist_next;

    assign hist_next = {hist_reg[HISTORY_BITS-2:0], level};

    // Pattern match on the shifted history, flags valid with sample_en
    assign edges.rise = (hist_next == HISTORY_BITS'(RISE_PATTERN));
    assign edges.fall = (hist_next == HISTORY_BITS'(FALL_PATTERN));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg <= '0;
        end else if (sample_en) begin
            hist_reg <= hist_next;
        end
    end

endmodule

// ===== rtl/core/ept_position.sv =====
// Rise counter with run-length wrap and held trigger window compare.
module ept_position
    import ept_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                sample_en,
    input  edge_t               edges,
    input  cfg_t                cfg,
    output logic                trigger_next,
    output logic [CNT_BITS-1:0] count_next
);

    logic [CNT_BITS-1:0]          count_reg;
    logic                         trigger_reg;
    logic [CNT_BITS-1:0]          count_inc;
    logic signed [BOUND_BITS-1:0] lo_bound;
    logic signed [BOUND_BITS-1:0] hi_bound;
    logic signed [BOUND_BITS-1:0] count_s;
    logic                         in_window;

    // Window bounds in signed arithmetic wide enough to never wrap
    assign lo_bound = $signed({3'b000, cfg.start_position})
                    + BOUND_BITS'(cfg.slip_offset);
    assign hi_bound = lo_bound + $signed({3'b000, cfg.pulse_width});

    assign count_inc = edges.rise ? count_reg + 1'b1 : count_reg;
    assign count_s   = $signed({3'b000, count_inc});
    assign in_window = (count_s >= lo_bound) && (count_s < hi_bound);

    // Trigger recomputed only on a rise; counter returns to zero at run length
    assign trigger_next = edges.rise ? in_window : trigger_reg;
    assign count_next   = (count_inc == cfg.run_length) ? '0 : count_inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            trigger_reg <= 1'b0;
        end else if (sample_en) begin
            count_reg   <= count_next;
            trigger_reg <= trigger_next;
        end
    end

endmodule

// ===== rtl/core/encoder_position_trigger_window_unit.sv =====
// Encoder position trigger window unit: one sample word in, one result word out.
// Output is registered: a result word shows on m_tdata the cycle after its sample.
// Throughput: one sample word per cycle; the output register refills on the
// same edge its word is taken, so s_tready stays high while m_tready is high.
// Reset (aresetn low, synchronous): history, counter and trigger clear, the
// output register empties and the configuration returns to its defaults.
module encoder_position_trigger_window_unit
    import ept_pkg::*;
#(
    parameter int HISTORY_BITS = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // Sample stream
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [7:0]               s_tdata,   // [0] encoder_level, [7:1] zero
    // Result stream
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [23:0]              m_tdata,   // [0] trigger_out, [1] rise_seen,
                                                // [2] fall_seen, [18:3] position_count,
                                                // [23:19] zero
    // Configuration
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    cfg_t                cfg;
    edge_t               edges;
    logic                sample_en;
    logic                trigger_next;
    logic [CNT_BITS-1:0] count_next;

    logic                out_valid_reg;
    logic [18:0]         out_data_reg;

    assign s_tready  = !out_valid_reg || m_tready;
    assign sample_en = s_tvalid && s_tready;

    ept_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ept_edge_detect #(
        .HISTORY_BITS (HISTORY_BITS)
    ) u_edge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .sample_en (sample_en),
        .level     (s_tdata[0]),
        .edges     (edges)
    );

    ept_position u_pos (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .sample_en    (sample_en),
        .edges        (edges),
        .cfg          (cfg),
        .trigger_next (trigger_next),
        .count_next   (count_next)
    );

    // Output register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_tready) begin
            out_valid_reg <= s_tvalid;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (sample_en) begin
            out_data_reg <= {count_next, edges.fall, edges.rise, trigger_next};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_data_reg};

endmodule
